@@ rtl/tbpeq_pkg.sv @@
`default_nettype none

package tbpeq_pkg;

  // PCM sample and inter-band data formats
  localparam int PCM_W     = 16;
  localparam int DATA_W    = 26;   // Q17.8
  localparam int DATA_FRAC = 8;

  // config register indexes: enable first, then ff/fb pairs per band
  localparam int REG_ENABLE    = 0;
  localparam int REG_BAND_BASE = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DRAIN,
    ST_WRITE,
    ST_FINISH
  } st_t;

  // product terms of one section, in MAC order
  typedef enum logic [2:0] {
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } term_t;

  // one history word per band and channel
  typedef struct packed {
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] x1;
  } hist_t;

endpackage

`default_nettype wire

@@ rtl/tbpeq_ram.sv @@
`default_nettype none

module tbpeq_ram #(
  parameter int WIDTH = 104,
  parameter int DEPTH = 6,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/three_band_peaking_eq_core.sv @@
`default_nettype none

// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: sample_in[15:0]; tuser: channel_in
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: sample_out[15:0]; tuser: channel_out
// cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data (always ready)
//
// Filtered request: no new request is taken until this one has left FINISH. Each
// band runs a history read, five products through the one shared multiplier, a
// drain and a write-back; the single multiplier sets the rate. Bypass: IDLE to FINISH.
// Reset: coefficients go to unity gain, enable off, history valid bits
// clear (no RAM sweep; an unwritten entry reads as zero).
// Stalls: result sits in the output register; a new request is taken while
// it waits, and the next result holds in FINISH until the register frees.

module three_band_peaking_eq_core #(
  parameter int CHANNELS       = 2,
  parameter int BANDS          = 3,
  parameter int COEF_FRAC_BITS = 16,
  localparam int COEF_W    = 4 + COEF_FRAC_BITS,
  localparam int FF_W      = 3 * COEF_W,
  localparam int CFG_IDX_W = $clog2(2 * BANDS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // input samples
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tbpeq_pkg::PCM_W-1:0]   s_axis_tdata,   // [15:0] sample_in
  input  logic                          s_axis_tuser,   // [0] channel_in
  // equalized samples
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tbpeq_pkg::PCM_W-1:0]   m_axis_tdata,   // [15:0] sample_out
  output logic                          m_axis_tuser,   // [0] channel_out
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [FF_W-1:0]               cfg_data
);

  import tbpeq_pkg::*;

  localparam int FB_W   = 2 * COEF_W;
  localparam int SLOTS  = BANDS * CHANNELS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;   // five terms

  localparam logic [FF_W-1:0] FF_RESET = FF_W'(1) << (2 * COEF_W + COEF_FRAC_BITS);

  localparam logic signed [ACC_W-1:0] Y_MAX =
    ACC_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -(ACC_W'(64'sd1 <<< (DATA_W - 1)));

  localparam logic signed [DATA_W-1:0] RND_BIAS = DATA_W'((1 << DATA_FRAC) - 1);
  localparam logic signed [DATA_W-1:0] PCM_MAX  = DATA_W'((1 << (PCM_W - 1)) - 1);
  localparam logic signed [DATA_W-1:0] PCM_MIN  = -(DATA_W'(1 << (PCM_W - 1)));

  // ---------------- configuration registers ----------------
  logic            eq_enable;
  logic [FF_W-1:0] ff [BANDS];
  logic [FB_W-1:0] fb [BANDS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eq_enable <= 1'b0;
      for (int b = 0; b < BANDS; b++) begin
        ff[b] <= FF_RESET;
        fb[b] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_W'(REG_ENABLE)) begin
        eq_enable <= cfg_data[0];
      end
      for (int b = 0; b < BANDS; b++) begin
        if (cfg_index == CFG_IDX_W'(REG_BAND_BASE + 2 * b)) begin
          ff[b] <= cfg_data;
        end
        if (cfg_index == CFG_IDX_W'(REG_BAND_BASE + 2 * b + 1)) begin
          fb[b] <= cfg_data[FB_W-1:0];
        end
      end
    end
  end

  // ---------------- sequencer ----------------
  st_t   st, st_next;
  term_t term, term_next;
  logic  rd_en, wr_en, out_load;

  logic [BAND_W-1:0]        band;
  logic                     item_ch;
  logic                     use_ch;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] x;        // section input, later the final output
  logic [SLOTS-1:0]         slot_valid;
  logic                     hist_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next       = st;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    unique case (st)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          st_next = eq_enable ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        st_next = ST_MAC;
      end
      ST_MAC: begin
        if (term == TERM_A2) begin
          st_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_next = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        st_next = (band == BAND_W'(BANDS - 1)) ? ST_FINISH : ST_READ;
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (term)
      TERM_B0: term_next = TERM_B1;
      TERM_B1: term_next = TERM_B2;
      TERM_B2: term_next = TERM_A1;
      TERM_A1: term_next = TERM_A2;
      TERM_A2: term_next = TERM_A2;
      default: term_next = TERM_B0;
    endcase
  end

  // channels past the configured count share the last one's history
  assign use_ch = (CHANNELS > 1) ? item_ch : 1'b0;
  assign slot   = SLOT_W'(int'(band) * CHANNELS + int'(use_ch));

  // ---------------- history memory ----------------
  hist_t ram_rd, hist, hist_wr;

  tbpeq_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (SLOTS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (hist_wr),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd)
  );

  // entries never written read as zero
  assign hist = hist_ok ? ram_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[slot] <= 1'b1;
    end
  end

  // ---------------- shared MAC ----------------
  logic signed [DATA_W-1:0] op_d;
  logic signed [COEF_W-1:0] op_c;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_sub;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [DATA_W-1:0] y_sat;

  always_comb begin
    case (term)
      TERM_B0: begin
        op_d = x;
        op_c = $signed(ff[band][2*COEF_W +: COEF_W]);
      end
      TERM_B1: begin
        op_d = hist.x1;
        op_c = $signed(ff[band][COEF_W +: COEF_W]);
      end
      TERM_B2: begin
        op_d = hist.x2;
        op_c = $signed(ff[band][0 +: COEF_W]);
      end
      TERM_A1: begin
        op_d = hist.y1;
        op_c = $signed(fb[band][COEF_W +: COEF_W]);
      end
      TERM_A2: begin
        op_d = hist.y2;
        op_c = $signed(fb[band][0 +: COEF_W]);
      end
      default: begin
        op_d = '0;
        op_c = '0;
      end
    endcase
  end

  // floor shift, then clamp to Q17.8
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  always_comb begin
    if (acc_sh > Y_MAX) begin
      y_sat = Y_MAX[DATA_W-1:0];
    end else if (acc_sh < Y_MIN) begin
      y_sat = Y_MIN[DATA_W-1:0];
    end else begin
      y_sat = acc_sh[DATA_W-1:0];
    end
  end

  always_comb begin
    hist_wr.x1 = x;
    hist_wr.x2 = hist.x1;
    hist_wr.y1 = y_sat;
    hist_wr.y2 = hist.y1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (st == ST_MAC);
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE && s_axis_tvalid) begin
      x       <= {{(DATA_W - PCM_W - DATA_FRAC){s_axis_tdata[PCM_W-1]}},
                  s_axis_tdata, {DATA_FRAC{1'b0}}};
      item_ch <= s_axis_tuser;
      band    <= '0;
    end
    if (st == ST_READ) begin
      hist_ok <= slot_valid[slot];
      term    <= TERM_B0;
    end
    if (st == ST_MAC) begin
      prod     <= op_d * op_c;
      prod_sub <= (term == TERM_A1) || (term == TERM_A2);
      term     <= term_next;
    end
    if (st == ST_READ) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= prod_sub ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (st == ST_WRITE) begin
      x    <= y_sat;
      band <= band + BAND_W'(1);
    end
  end

  // ---------------- output register ----------------
  // Q17.8 to PCM: truncate toward zero, clamp to 16 bits
  logic signed [DATA_W-1:0] x_rnd;
  logic signed [DATA_W-1:0] x_int;
  logic [PCM_W-1:0]         pcm;

  assign x_rnd = x[DATA_W-1] ? x + RND_BIAS : x;
  assign x_int = x_rnd >>> DATA_FRAC;
  always_comb begin
    if (x_int > PCM_MAX) begin
      pcm = PCM_MAX[PCM_W-1:0];
    end else if (x_int < PCM_MIN) begin
      pcm = PCM_MIN[PCM_W-1:0];
    end else begin
      pcm = x_int[PCM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= pcm;
      m_axis_tuser <= item_ch;
    end
  end

endmodule

`default_nettype wire
